// File: src/skht_pkg.sv
// ----------------------------------------------------------------------------
// skht_pkg
// Shared constants and types for the string-key hash table.
// ----------------------------------------------------------------------------
package skht_pkg;

  localparam int TableSlots = 128;
  localparam int MaxKeyLen  = 20;
  localparam int HashSeed   = 5381;

  localparam int SlotW  = $clog2(TableSlots);
  localparam int LenW   = $clog2(MaxKeyLen + 1);
  localparam int PosW   = (MaxKeyLen > 1) ? $clog2(MaxKeyLen) : 1;
  localparam int KeyMemDepth = TableSlots * MaxKeyLen;
  localparam int KeyAddrW    = $clog2(KeyMemDepth);

  localparam logic [SlotW-1:0] HashInit = SlotW'(HashSeed % TableSlots);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_FULL      = 3'd3,
    ST_SKIPPED   = 3'd4
  } status_t;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // Command from front to back.
  typedef struct packed {
    logic             req_type;
    logic             overlong;
    logic [LenW-1:0]  key_len;
    logic [SlotW-1:0] hash;
    logic [6:0]       insert_value;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] found_value;
    logic [6:0] slot_index;
  } result_t;

endpackage

// File: src/skht_ram.sv
// ----------------------------------------------------------------------------
// skht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module skht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/skht_front.sv
// ----------------------------------------------------------------------------
// skht_front
// Collects key bytes, runs the hash, and issues a command at each terminator.
// Key bytes go into one of two buffer banks; the bank flips per command.
// ----------------------------------------------------------------------------
module skht_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [7:0]                   key_byte,
  input  logic [6:0]                   insert_value,
  // key buffer write port
  output logic                         kb_we,
  output logic [skht_pkg::PosW:0]      kb_waddr,
  output logic [7:0]                   kb_wdata,
  // command queue push
  output logic                         cmd_push,
  output skht_pkg::cmd_t               cmd,
  input  logic                         cmd_full,
  input  logic                         bank_free
);

  logic [skht_pkg::LenW-1:0]  key_count;
  logic [skht_pkg::SlotW-1:0] running_hash;
  logic                       key_overlong;
  logic                       bank;
  logic                       is_term;
  logic [skht_pkg::SlotW+5:0] hash_wide;

  assign is_term  = (key_byte == 8'd0);
  assign in_ready = !is_term || (!cmd_full && bank_free);

  assign hash_wide = ({6'd0, running_hash} << 5) + {6'd0, running_hash}
                     + (skht_pkg::SlotW + 6)'(key_byte);

  assign kb_we    = in_valid && in_ready && !is_term
                    && (key_count < skht_pkg::LenW'(skht_pkg::MaxKeyLen));
  assign kb_waddr = {bank, key_count[skht_pkg::PosW-1:0]};
  assign kb_wdata = key_byte;

  assign cmd_push          = in_valid && in_ready && is_term;
  assign cmd.req_type      = req_type;
  assign cmd.overlong      = key_overlong;
  assign cmd.key_len       = key_count;
  assign cmd.hash          = running_hash;
  assign cmd.insert_value  = insert_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count    <= '0;
      running_hash <= skht_pkg::HashInit;
      key_overlong <= 1'b0;
      bank         <= 1'b0;
    end else if (in_valid && in_ready) begin
      if (is_term) begin
        key_count    <= '0;
        running_hash <= skht_pkg::HashInit;
        key_overlong <= 1'b0;
        bank         <= !bank;
      end else begin
        running_hash <= hash_wide[skht_pkg::SlotW-1:0];
        if (kb_we) begin
          key_count <= key_count + 1'b1;
        end else begin
          key_overlong <= 1'b1;
        end
      end
    end
  end

endmodule

// File: src/skht_back.sv
// ----------------------------------------------------------------------------
// skht_back
// Probe sequencer: walks slots from the hash, compares keys byte by byte,
// writes inserts, and holds one result in an output register.
// ----------------------------------------------------------------------------
module skht_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  skht_pkg::cmd_t          cmd,
  output logic                    cmd_pop,
  output logic [skht_pkg::PosW:0] kb_raddr,
  input  logic [7:0]              kb_rdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output skht_pkg::result_t       result
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_RD, S_CHK, S_CMP, S_CMPW, S_WR, S_WRW, S_DONE
  } state_t;

  state_t                       state;
  skht_pkg::cmd_t               cur;
  skht_pkg::result_t            res_hold;
  logic                         bank;
  logic [skht_pkg::SlotW-1:0]   pos;
  logic [skht_pkg::SlotW:0]     probes;
  logic [skht_pkg::LenW-1:0]    idx;
  logic [skht_pkg::SlotW-1:0]   clr_addr;

  // slot metadata RAM: {value, length}
  logic                         meta_we;
  logic [skht_pkg::SlotW-1:0]   meta_waddr;
  logic [6+skht_pkg::LenW:0]    meta_wdata;
  logic [6+skht_pkg::LenW:0]    meta_rdata;
  logic [6:0]                   m_value;
  logic [skht_pkg::LenW-1:0]    m_len;

  logic                         key_we;
  logic [skht_pkg::KeyAddrW-1:0] key_waddr;
  logic [skht_pkg::KeyAddrW-1:0] key_raddr;
  logic [7:0]                   key_rdata;
  logic [skht_pkg::KeyAddrW-1:0] slot_base;
  logic [skht_pkg::KeyAddrW-1:0] idx_ext;
  logic [skht_pkg::SlotW-1:0]   pos_inc;
  logic                         last_probe;

  assign m_value   = meta_rdata[6+skht_pkg::LenW:skht_pkg::LenW];
  assign m_len     = meta_rdata[skht_pkg::LenW-1:0];
  assign slot_base = skht_pkg::KeyAddrW'(pos) * skht_pkg::KeyAddrW'(skht_pkg::MaxKeyLen);
  assign idx_ext   = skht_pkg::KeyAddrW'(idx);
  assign pos_inc   = (pos == skht_pkg::SlotW'(skht_pkg::TableSlots - 1)) ? '0 : pos + 1'b1;
  assign last_probe = (probes == (skht_pkg::SlotW + 1)'(skht_pkg::TableSlots - 1));
  assign kb_raddr  = {bank, idx[skht_pkg::PosW-1:0]};
  assign key_raddr = slot_base + idx_ext;
  assign key_waddr = slot_base + idx_ext - 1'b1;

  assign meta_we    = (state == S_CLEAR) || (state == S_WRW);
  assign meta_waddr = (state == S_CLEAR) ? clr_addr : pos;
  assign meta_wdata = (state == S_CLEAR) ? '0 : {cur.insert_value, cur.key_len};
  assign key_we     = (state == S_WR) && (idx != '0);
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;

  skht_ram #(.Width(7 + skht_pkg::LenW), .Depth(skht_pkg::TableSlots)) u_meta (
    .clk, .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .raddr(pos), .rdata(meta_rdata)
  );

  skht_ram #(.Width(8), .Depth(skht_pkg::KeyMemDepth)) u_keys (
    .clk, .we(key_we), .waddr(key_waddr), .wdata(kb_rdata),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      bank      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == skht_pkg::SlotW'(skht_pkg::TableSlots - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            cur    <= cmd;
            pos    <= cmd.hash;
            probes <= '0;
            idx    <= '0;
            if (cmd.overlong) begin
              res_hold <= '{skht_pkg::ST_TOO_LONG, 7'd0, 7'd0};
              state    <= S_DONE;
            end else if (cmd.req_type == skht_pkg::REQ_INSERT
                         && (cmd.key_len == '0 || cmd.insert_value == 7'd0)) begin
              res_hold <= '{skht_pkg::ST_SKIPPED, 7'd0, 7'd0};
              state    <= S_DONE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          idx   <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (m_value == 7'd0) begin
            if (cur.req_type == skht_pkg::REQ_INSERT) begin
              idx   <= '0;
              state <= S_WR;
            end else begin
              res_hold <= '{skht_pkg::ST_NOT_FOUND, 7'd0, 7'd0};
              state    <= S_DONE;
            end
          end else if (cur.req_type == skht_pkg::REQ_LOOKUP && m_len == cur.key_len) begin
            idx   <= '0;
            state <= S_CMP;
          end else if (last_probe) begin
            if (cur.req_type == skht_pkg::REQ_INSERT) begin
              res_hold <= '{skht_pkg::ST_FULL, 7'd0, 7'd0};
            end else begin
              res_hold <= '{skht_pkg::ST_NOT_FOUND, 7'd0, 7'd0};
            end
            state <= S_DONE;
          end else begin
            pos    <= pos_inc;
            probes <= probes + 1'b1;
            state  <= S_RD;
          end
        end
        S_CMP: begin
          if (idx == cur.key_len) begin
            res_hold <= '{skht_pkg::ST_OK, m_value, 7'(pos)};
            state    <= S_DONE;
          end else begin
            state <= S_CMPW;
          end
        end
        S_CMPW: begin
          if (key_rdata == kb_rdata) begin
            idx   <= idx + 1'b1;
            state <= S_CMP;
          end else if (last_probe) begin
            res_hold <= '{skht_pkg::ST_NOT_FOUND, 7'd0, 7'd0};
            state    <= S_DONE;
          end else begin
            pos    <= pos_inc;
            probes <= probes + 1'b1;
            state  <= S_RD;
          end
        end
        S_WR: begin
          // buffer read is registered, so its data trails the index
          if (idx == cur.key_len) begin
            state <= S_WRW;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_WRW: begin
          res_hold <= '{skht_pkg::ST_OK, 7'd0, 7'(pos)};
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            result    <= res_hold;
            out_valid <= 1'b1;
            bank      <= !bank;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/skht_queue.sv
// ----------------------------------------------------------------------------
// skht_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module skht_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  skht_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output skht_pkg::cmd_t dout
);

  skht_pkg::cmd_t mem [2];
  logic           wp;
  logic           rp;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/string_key_hash_table.sv
// ----------------------------------------------------------------------------
// string_key_hash_table
// djb2-hashed open-addressed table keyed by byte strings, linear probing.
// ----------------------------------------------------------------------------
// Key bytes: one per cycle, no result. Terminator: the result follows a linear probe
// from the hashed slot, a byte-by-byte compare on a length match for lookups, and
// on insert a write of the key bytes; overlong and skipped requests skip the probe.
// The next terminator waits until the previous result is formed.
// Reset: synchronous; a clearing pass over all TableSlots (128) slots empties the
// slot RAM; one terminator may queue meanwhile, later ones are held off.
// ----------------------------------------------------------------------------
module string_key_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // key_byte[7:0], insert_value[14:8]
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[2:0], found_value[9:3], slot_index[16:10]
);

  logic                    kb_we;
  logic [skht_pkg::PosW:0] kb_waddr;
  logic [7:0]              kb_wdata;
  logic [skht_pkg::PosW:0] kb_raddr;
  logic [7:0]              kb_rdata;
  logic                    cmd_push;
  logic                    cmd_full;
  logic                    cmd_pop;
  logic                    cmd_valid;
  skht_pkg::cmd_t          cmd_in;
  skht_pkg::cmd_t          cmd_out;
  skht_pkg::result_t       result;
  logic [1:0]              banks_used;
  logic                    m_tvalid_set;
  logic                    m_tvalid_q;

  // a bank is busy from terminator until its result is formed
  always_ff @(posedge clk) begin
    if (rst) begin
      banks_used <= '0;
    end else begin
      banks_used <= banks_used + {1'b0, cmd_push}
                    - {1'b0, (m_tvalid_set)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid_q <= 1'b0;
    else     m_tvalid_q <= m_tvalid && !m_tready ? 1'b1 : 1'b0;
  end
  assign m_tvalid_set = m_tvalid && !m_tvalid_q;

  skht_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .req_type(s_tuser), .key_byte(s_tdata[7:0]), .insert_value(s_tdata[14:8]),
    .kb_we, .kb_waddr, .kb_wdata,
    .cmd_push, .cmd(cmd_in), .cmd_full,
    .bank_free(banks_used == 2'd0)
  );

  skht_ram #(.Width(8), .Depth(2 ** (skht_pkg::PosW + 1))) u_keybuf (
    .clk, .we(kb_we), .waddr(kb_waddr), .wdata(kb_wdata),
    .raddr(kb_raddr), .rdata(kb_rdata)
  );

  skht_queue u_queue (
    .clk, .rst, .push(cmd_push), .din(cmd_in), .full(cmd_full),
    .pop(cmd_pop), .valid(cmd_valid), .dout(cmd_out)
  );

  skht_back u_back (
    .clk, .rst, .cmd_valid, .cmd(cmd_out), .cmd_pop, .kb_raddr, .kb_rdata,
    .out_valid(m_tvalid), .out_ready(m_tready), .result
  );

  assign m_tdata = {7'd0, result.slot_index, result.found_value, result.status};

endmodule

// File: src/skht_checker.sv
// ----------------------------------------------------------------------------
// skht_checker
// Port-level checks for the string-key hash table.
// ----------------------------------------------------------------------------
module skht_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= skht_pkg::ST_SKIPPED)
    else $error("bad status code");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != skht_pkg::ST_OK |-> m_tdata[16:3] == 14'd0)
    else $error("failed request carries data");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result after reset");

  a_bytes_taken: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tdata[7:0] != 8'd0 |-> s_tready)
    else $error("key byte refused");

endmodule

bind string_key_hash_table skht_checker u_skht_checker (
  .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
);
